>>> design/ibt_pkg.sv
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants for the interval booking table.
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TIME_BITS   = 32;
    localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_BITS  = 32;
    localparam int USED_BITS   = 7;

    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_time;
        logic [FIELD_BITS-1:0] end_time;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [USED_BITS-1:0] entries_used;
    } t_rsp;

    typedef struct packed {
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
    } t_entry;

endpackage

>>> design/ibt_table_mem.sv
// ----------------------------------------------------------------------------
// ibt_table_mem
// Interval storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ibt_table_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ibt_pkg::ADDR_BITS-1:0] i_waddr,
    input  ibt_pkg::t_entry               i_wdata,
    input  logic                          i_re,
    input  logic [ibt_pkg::ADDR_BITS-1:0] i_raddr,
    output ibt_pkg::t_entry               o_rdata
);

    ibt_pkg::t_entry r_mem [ibt_pkg::TABLE_DEPTH];
    ibt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/interval_booking_table_unit.sv
// ----------------------------------------------------------------------------
// interval_booking_table_unit
// Reservation table for half-open time intervals with an overlap check.
// ----------------------------------------------------------------------------
// A request word [start_time, end_time) is taken at a clock edge where start
// is high and busy is low. Exactly one result word follows, shown on o_rsp for
// one cycle while o_done is high; the receiver must take it then, it cannot
// hold results off. A request that is empty or reversed, that meets a full
// table, or that meets an empty table is answered in the cycle right after it
// is taken and busy never rises. Any other request scans every stored entry
// through the single read port of the table memory while busy is high: one
// read per stored entry, then the last compare, then a step that decides the
// result and writes the new entry back.
// The result is registered, so a new request may be taken in the cycle its
// predecessor's result is on the ports. Stored entries are the slots below the
// fill count, so reset needs no clearing pass over the memory.
// ----------------------------------------------------------------------------
module interval_booking_table_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ibt_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ibt_pkg::t_rsp o_rsp
);

    // request interval, cut or extended to the time width
    logic [ibt_pkg::TIME_BITS-1:0] w_lo;
    logic [ibt_pkg::TIME_BITS-1:0] w_hi;

    ibt_pkg::t_state               r_state, n_state;
    logic [ibt_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [ibt_pkg::COUNT_BITS-1:0] r_idx, n_idx;
    logic                          r_cmp_vld, n_cmp_vld;
    logic                          r_hit, n_hit;
    logic [ibt_pkg::TIME_BITS-1:0] r_lo, n_lo;
    logic [ibt_pkg::TIME_BITS-1:0] r_hi, n_hi;
    logic                          r_done, n_done;
    ibt_pkg::t_rsp                 r_rsp, n_rsp;

    logic                          w_we;
    ibt_pkg::t_entry               w_wdata;
    logic                          w_re;
    ibt_pkg::t_entry               w_rdata;
    logic                          w_hit_now;
    logic                          w_take;

    assign w_lo   = ibt_pkg::TIME_BITS'(i_req.start_time);
    assign w_hi   = ibt_pkg::TIME_BITS'(i_req.end_time);
    assign w_take = start && (r_state == ibt_pkg::S_IDLE);

    // compare the entry read last cycle against the pending request
    assign w_hit_now = r_cmp_vld && (w_rdata.lo < r_hi) && (w_rdata.hi > r_lo);

    ibt_table_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ibt_pkg::ADDR_BITS-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[ibt_pkg::ADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ibt_pkg::S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_rsp <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_hit     = r_hit;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_wdata   = '{lo: w_lo, hi: w_hi};

        case (r_state)
            ibt_pkg::S_IDLE: begin
                if (start) begin
                    n_lo = w_lo;
                    n_hi = w_hi;
                    if (w_lo >= w_hi) begin
                        // empty or reversed: answer at once, keep the table
                        n_done = 1'b1;
                        n_rsp  = '{status: ibt_pkg::ST_INVALID,
                                   entries_used: ibt_pkg::USED_BITS'(r_count)};
                    end else if (r_count == ibt_pkg::COUNT_BITS'(ibt_pkg::TABLE_DEPTH)) begin
                        n_done = 1'b1;
                        n_rsp  = '{status: ibt_pkg::ST_FULL,
                                   entries_used: ibt_pkg::USED_BITS'(r_count)};
                    end else if (r_count == '0) begin
                        // nothing to scan: store straight away
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_done  = 1'b1;
                        n_rsp   = '{status: ibt_pkg::ST_ACCEPT,
                                    entries_used: ibt_pkg::USED_BITS'(n_count)};
                    end else begin
                        n_state = ibt_pkg::S_SCAN;
                        n_idx   = '0;
                        n_hit   = 1'b0;
                    end
                end
            end
            ibt_pkg::S_SCAN: begin
                n_hit = r_hit || w_hit_now;
                if (r_idx != r_count) begin
                    // issue the next read, compare it in the cycle after
                    w_re      = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else if (!r_cmp_vld) begin
                    // last compare has landed: decide and write back
                    n_state = ibt_pkg::S_IDLE;
                    n_done  = 1'b1;
                    w_wdata = '{lo: r_lo, hi: r_hi};
                    if (r_hit) begin
                        n_rsp = '{status: ibt_pkg::ST_OVERLAP,
                                  entries_used: ibt_pkg::USED_BITS'(r_count)};
                    end else begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_rsp   = '{status: ibt_pkg::ST_ACCEPT,
                                    entries_used: ibt_pkg::USED_BITS'(n_count)};
                    end
                end
            end
            default: begin
                n_state = ibt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != ibt_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ibt_pkg::COUNT_BITS'(ibt_pkg::TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // every table write is reported as an accepted request
    a_write_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (o_done && (o_rsp.status == ibt_pkg::ST_ACCEPT)))
        else $error("table write without accept result");

    // an empty interval is rejected in the next cycle
    a_invalid_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (w_lo >= w_hi)) |=>
            (o_done && (o_rsp.status == ibt_pkg::ST_INVALID)))
        else $error("empty interval not rejected");

    // reported count matches the fill count after the request
    a_used_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.entries_used == ibt_pkg::USED_BITS'(r_count)))
        else $error("entries_used out of step with fill count");

    // no read and write of the table in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("read and write collide on table memory");

endmodule
